/* hw/rtl/dks_pkg.sv */
// ----------------------------------------------------------------------------
// Depth key sorter package
// Shared constants and types for the depth key sorter.
// ----------------------------------------------------------------------------
package dks_pkg;

  localparam int DEPTH    = 64;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = IDX_W + 1;
  localparam int KEY_W    = 32;
  localparam int PL_W     = 34;
  localparam int QDEPTH   = 4;
  localparam int QIDX_W   = $clog2(QDEPTH);

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PL_W-1:0]  pl;
    logic             last;
  } req_t;

endpackage

/* hw/rtl/dks_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module dks_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/dks_front.sv */
// ----------------------------------------------------------------------------
// Depth key sorter front end
// Accepts input requests and queues them for the sorting engine.
// ----------------------------------------------------------------------------
module dks_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  dks_pkg::req_t in_req,
  output logic          q_valid,
  input  logic          q_pop,
  output dks_pkg::req_t q_req
);
  import dks_pkg::*;

  req_t              q_r [QDEPTH];
  logic [QIDX_W-1:0] wp_r, rp_r;
  logic [QIDX_W:0]   cnt_r;
  logic              push;

  assign in_stall = (cnt_r == (QIDX_W+1)'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_req    = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= in_req;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (q_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (QIDX_W+1)'(push) - (QIDX_W+1)'(q_pop);
    end
  end

endmodule

/* hw/rtl/dks_back.sv */
// ----------------------------------------------------------------------------
// Depth key sorter back end
// Stores entries, keeps a sorted position list and emits the batch.
// ----------------------------------------------------------------------------
module dks_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  output logic                     q_pop,
  input  dks_pkg::req_t            q_req,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [dks_pkg::KEY_W-1:0] out_key,
  output logic [dks_pkg::PL_W-1:0]  out_pl,
  output logic [dks_pkg::IDX_W-1:0] out_pos,
  output logic                     out_last,
  output logic                     out_drop
);
  import dks_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_ORD, S_RD, S_EMIT_RD, S_EMIT_W, S_EMIT}
    state_t;

  state_t           st_r;
  logic [CNT_W-1:0] cnt_r;
  logic             ovf_r;
  logic [KEY_W-1:0] nkey_r;
  logic             nlast_r;
  logic [CNT_W-1:0] k_r;
  logic [CNT_W-1:0] e_r;

  logic             we;
  logic [KEY_W-1:0] krd;
  logic [PL_W-1:0]  prd;
  logic             ow;
  logic             shift;
  logic [IDX_W-1:0] oraddr;
  logic [IDX_W-1:0] owdata;
  logic [IDX_W-1:0] ord_rd;

  // The order memory is read at the entry before the insertion point while
  // scanning, and at the emitted rank while draining. The key and payload
  // memories are always read at the position that the order memory returns.
  assign we = (st_r == S_IDLE) && q_valid && (cnt_r != CNT_W'(DEPTH));
  always_comb begin
    if (st_r == S_EMIT_RD || st_r == S_EMIT_W || st_r == S_EMIT) begin
      oraddr = e_r[IDX_W-1:0];
    end else begin
      oraddr = k_r[IDX_W-1:0] - IDX_W'(1);
    end
  end

  // A strictly smaller new key moves the compared entry up one place.
  assign shift  = (st_r == S_RD) && ($signed(nkey_r) < $signed(krd));
  assign ow     = ((st_r == S_SCAN) && (k_r == '0)) || (st_r == S_RD);
  assign owdata = shift ? ord_rd : cnt_r[IDX_W-1:0];

  dks_ram #(.WIDTH(IDX_W), .DEPTH(DEPTH)) u_ord (
    .clk, .we(ow), .waddr(k_r[IDX_W-1:0]), .wdata(owdata), .raddr(oraddr), .rdata(ord_rd)
  );
  dks_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_key (
    .clk, .we, .waddr(cnt_r[IDX_W-1:0]), .wdata(q_req.key), .raddr(ord_rd), .rdata(krd)
  );
  dks_ram #(.WIDTH(PL_W), .DEPTH(DEPTH)) u_pl (
    .clk, .we, .waddr(cnt_r[IDX_W-1:0]), .wdata(q_req.pl), .raddr(ord_rd), .rdata(prd)
  );

  assign q_pop     = (st_r == S_IDLE) && q_valid;
  assign out_valid = (st_r == S_EMIT);
  assign out_key   = krd;
  assign out_pl    = prd;
  assign out_pos   = ord_rd;
  assign out_last  = (e_r + 1'b1 == cnt_r);
  assign out_drop  = ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      cnt_r <= '0;
      ovf_r <= 1'b0;
      k_r   <= '0;
      e_r   <= '0;
    end else begin
      case (st_r)
        S_IDLE: begin
          if (q_valid) begin
            nlast_r <= q_req.last;
            nkey_r  <= q_req.key;
            k_r     <= cnt_r;
            if (we) begin
              st_r <= S_SCAN;
            end else begin
              ovf_r <= 1'b1;
              if (q_req.last) begin
                e_r  <= '0;
                st_r <= S_EMIT_RD;
              end
            end
          end
        end
        S_SCAN: begin
          // Insertion point search: each compare steps through S_SCAN, S_ORD and S_RD.
          if (k_r == '0) begin
            cnt_r <= cnt_r + 1'b1;
            e_r   <= '0;
            st_r  <= nlast_r ? S_EMIT_RD : S_IDLE;
          end else begin
            st_r <= S_ORD;
          end
        end
        S_ORD: st_r <= S_RD;
        S_RD: begin
          if (shift) begin
            k_r  <= k_r - 1'b1;
            st_r <= S_SCAN;
          end else begin
            cnt_r <= cnt_r + 1'b1;
            e_r   <= '0;
            st_r  <= nlast_r ? S_EMIT_RD : S_IDLE;
          end
        end
        S_EMIT_RD: st_r <= S_EMIT_W;
        S_EMIT_W:  st_r <= S_EMIT;
        S_EMIT: begin
          if (!out_stall) begin
            if (out_last) begin
              cnt_r <= '0;
              ovf_r <= 1'b0;
              st_r  <= S_IDLE;
            end else begin
              e_r  <= e_r + 1'b1;
              st_r <= S_EMIT_RD;
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/depth_key_sorter.sv */
// ----------------------------------------------------------------------------
// Depth key sorter
// Stable ascending sort of a batch of render-list entries by depth key.
// ----------------------------------------------------------------------------
// Entries are loaded one request at a time into a four-deep queue; the back
// end takes each one, writes it to the key and payload memories at the next
// free position and inserts that position into a sorted order list by
// stepping down the list one compare at a time, each step reading the order
// memory and then the key memory through their registered ports, so loading
// entry n (counted from zero) takes up to n compares. Equal keys keep their
// load order. After the entry marked last, every stored entry is emitted in
// ascending key order, one result at a time and held while out_stall is high,
// the final one marked; entries beyond 64 are dropped and every result of
// that batch reports the drop. A batch holding only dropped entries cannot
// occur, since the store fills first.
// ----------------------------------------------------------------------------
module depth_key_sorter (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [31:0]       in_depth_key,
  input  logic [1:0]               in_entry_kind,
  input  logic [15:0]              in_ref_first,
  input  logic [15:0]              in_ref_second,
  input  logic                     in_last_entry,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [31:0]       out_sorted_key,
  output logic [1:0]               out_sorted_kind,
  output logic [15:0]              out_sorted_first,
  output logic [15:0]              out_sorted_second,
  output logic [5:0]               out_load_position,
  output logic                     out_last_result,
  output logic                     out_entries_dropped
);
  import dks_pkg::*;

  req_t             in_req, q_req;
  logic             q_valid, q_pop;
  logic [KEY_W-1:0] key;
  logic [PL_W-1:0]  pl;

  assign in_req.key  = in_depth_key;
  assign in_req.pl   = {in_ref_second, in_ref_first, in_entry_kind};
  assign in_req.last = in_last_entry;

  dks_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_req, .q_valid, .q_pop, .q_req
  );

  dks_back u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_req, .out_valid, .out_stall,
    .out_key(key), .out_pl(pl), .out_pos(out_load_position),
    .out_last(out_last_result), .out_drop(out_entries_dropped)
  );

  assign out_sorted_key    = key;
  assign out_sorted_kind   = pl[1:0];
  assign out_sorted_first  = pl[17:2];
  assign out_sorted_second = pl[33:18];

endmodule
